>>> rtl/wstm_pkg.sv
// wstm_pkg: shared types, constants and character helpers for the word start text matcher
// no dependencies; imported by wstm_scan and word_start_text_matcher_unit
`default_nettype none

package wstm_pkg;

    localparam int CHAR_W       = 8;
    localparam int PAT_CHARS    = 16;
    localparam int PAT_WORD_W   = 64;
    localparam int PAT_LEN_W    = 5;
    localparam int RESULT_OFS_W = 16;
    localparam int CFG_IDX_W    = 2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_PAT_LOW  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PAT_HIGH = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PAT_LEN  = 2'd2;

    localparam logic [CHAR_W-1:0] CH_NUL    = 8'h00;
    localparam logic [CHAR_W-1:0] CH_LOW_A  = 8'h61;
    localparam logic [CHAR_W-1:0] CH_LOW_Z  = 8'h7A;
    localparam logic [CHAR_W-1:0] CH_UP_A   = 8'h41;
    localparam logic [CHAR_W-1:0] CH_UP_Z   = 8'h5A;
    localparam logic [CHAR_W-1:0] CH_DIG_0  = 8'h30;
    localparam logic [CHAR_W-1:0] CH_DIG_9  = 8'h39;

    typedef logic [CHAR_W-1:0] char_t;

    typedef struct packed {
        logic                    emit;
        logic                    found;
        logic [RESULT_OFS_W-1:0] offset;
    } scan_res_t;

    function automatic char_t fold_upper(input char_t c);
        char_t r;
        r = c;
        if (c >= CH_LOW_A && c <= CH_LOW_Z)
        begin
            r = char_t'(c - CH_LOW_A + CH_UP_A);
        end
        return r;
    endfunction

    // expects an already folded character
    function automatic logic is_alnum(input char_t c);
        return ((c >= CH_UP_A) && (c <= CH_UP_Z)) || ((c >= CH_DIG_0) && (c <= CH_DIG_9));
    endfunction

endpackage

`default_nettype wire

>>> rtl/wstm_scan.sv
// wstm_scan: character window, boundary flags, position counter and the parallel pattern compare
// depends on wstm_pkg
`default_nettype none

module wstm_scan #(
    parameter int MAX_PATTERN = 16,
    parameter int OFFSET_BITS = 16
) (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  step,
    input  wire wstm_pkg::char_t                       char_in,
    input  wire logic                                  last_in,
    input  wire logic [wstm_pkg::PAT_WORD_W-1:0]       pat_low,
    input  wire logic [wstm_pkg::PAT_WORD_W-1:0]       pat_high,
    input  wire logic [wstm_pkg::PAT_LEN_W-1:0]        pat_len,
    output wstm_pkg::scan_res_t                        res
);
    import wstm_pkg::*;

    char_t                  win_reg [MAX_PATTERN];
    logic                   bnd_reg [MAX_PATTERN];
    logic                   prev_alnum_reg;
    logic                   prev_alnum_next;
    logic                   reported_reg;
    logic                   reported_next;
    logic [OFFSET_BITS-1:0] cnt_reg;
    logic [OFFSET_BITS-1:0] cnt_next;

    char_t                  win_view [MAX_PATTERN];
    logic                   bnd_view [MAX_PATTERN];
    char_t                  patf [PAT_CHARS];
    logic [2*PAT_WORD_W-1:0] pat_all;
    char_t                  folded;
    logic                   is_nul;
    logic                   ends_text;
    logic [OFFSET_BITS-1:0] cnt_view;
    logic [OFFSET_BITS-1:0] ofs_full;
    logic                   eq_all;
    logic                   bnd_sel;
    logic                   hit;

    assign pat_all   = {pat_high, pat_low};
    assign folded    = fold_upper(char_in);
    assign is_nul    = (char_in == CH_NUL);
    assign ends_text = is_nul || last_in;
    assign cnt_view  = (cnt_reg == {OFFSET_BITS{1'b1}}) ? cnt_reg : cnt_reg + 1'b1;
    assign ofs_full  = cnt_view - OFFSET_BITS'(pat_len);

    always_comb
    begin
        for (int j = 0; j < PAT_CHARS; j++)
        begin
            patf[j] = fold_upper(pat_all[j*CHAR_W +: CHAR_W]);
        end
    end

    // window as it stands after this character is shifted in, entry 0 newest
    always_comb
    begin
        win_view[0] = folded;
        bnd_view[0] = !prev_alnum_reg;
        for (int k = 1; k < MAX_PATTERN; k++)
        begin
            win_view[k] = win_reg[k-1];
            bnd_view[k] = bnd_reg[k-1];
        end
    end

    // entry k holds pattern character len-1-k
    always_comb
    begin
        char_t pexp;
        eq_all  = 1'b1;
        bnd_sel = 1'b0;
        for (int k = 0; k < MAX_PATTERN; k++)
        begin
            pexp = '0;
            for (int j = 0; j < MAX_PATTERN; j++)
            begin
                if (PAT_LEN_W'(j + k + 1) == pat_len)
                begin
                    pexp = pexp | patf[j];
                end
            end
            if (PAT_LEN_W'(k) < pat_len && win_view[k] != pexp)
            begin
                eq_all = 1'b0;
            end
            if (PAT_LEN_W'(k + 1) == pat_len)
            begin
                bnd_sel = bnd_view[k];
            end
        end
    end

    assign hit = !is_nul && !reported_reg && eq_all && bnd_sel
              && (cnt_view >= OFFSET_BITS'(pat_len));

    always_comb
    begin
        res = '0;
        if (hit)
        begin
            res.emit   = 1'b1;
            res.found  = 1'b1;
            res.offset = RESULT_OFS_W'(ofs_full);
        end
        else if (ends_text)
        begin
            res.emit = !reported_reg;
        end
    end

    always_comb
    begin
        cnt_next        = cnt_reg;
        prev_alnum_next = prev_alnum_reg;
        reported_next   = reported_reg;
        if (step)
        begin
            if (ends_text)
            begin
                cnt_next        = '0;
                prev_alnum_next = 1'b0;
                reported_next   = 1'b0;
            end
            else
            begin
                cnt_next        = cnt_view;
                prev_alnum_next = is_alnum(folded);
                reported_next   = reported_reg || hit;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg        <= '0;
            prev_alnum_reg <= 1'b0;
            reported_reg   <= 1'b0;
        end
        else
        begin
            cnt_reg        <= cnt_next;
            prev_alnum_reg <= prev_alnum_next;
            reported_reg   <= reported_next;
        end
    end

    // entries beyond the count are never compared, so no clearing needed
    always_ff @(posedge clk)
    begin
        if (step && !is_nul)
        begin
            for (int k = 0; k < MAX_PATTERN; k++)
            begin
                win_reg[k] <= win_view[k];
                bnd_reg[k] <= bnd_view[k];
            end
        end
    end

    a_text_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
        step && ends_text |=> (cnt_reg == '0) && !reported_reg && !prev_alnum_reg)
        else $error("state not cleared at end of text");

    a_one_result_per_text: assert property (@(posedge clk) disable iff (!rst_n)
        reported_reg && !ends_text |-> !res.emit)
        else $error("second result inside one text");

    a_found_needs_length: assert property (@(posedge clk) disable iff (!rst_n)
        res.found |-> (cnt_view >= OFFSET_BITS'(pat_len)) && !is_nul)
        else $error("match reported before pattern length characters");

endmodule

`default_nettype wire

>>> rtl/word_start_text_matcher_unit.sv
// word_start_text_matcher_unit: top level with config registers, input register and result register
// depends on wstm_pkg and wstm_scan
//
//   channel   | direction | handshake              | payload
//   ----------+-----------+------------------------+---------------------------
//   in        | into      | in_valid / in_stall    | text_char, last
//   out       | out of    | out_valid / out_stall  | found, start_offset
//   cfg       | into      | cfg_write              | cfg_index, cfg_data
//
// one character per cycle sustained while the output does not stall a reporting item; a request is
// held in the input register and its result, if any, is then loaded into the result register
// the window compare is a single level of parallel byte compares, no iteration
// reset clears the counter, flags, handshake state and loads pattern length 1
// a stalled result holds the input register only when that item has to report
`default_nettype none

module word_start_text_matcher_unit #(
    parameter int MAX_PATTERN = 16,
    parameter int OFFSET_BITS = 16
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               in_valid,
    output logic                                    in_stall,
    input  wire logic [wstm_pkg::CHAR_W-1:0]        text_char,
    input  wire logic                               last,
    output logic                                    out_valid,
    input  wire logic                               out_stall,
    output logic                                    found,
    output logic [wstm_pkg::RESULT_OFS_W-1:0]       start_offset,
    input  wire logic                               cfg_write,
    input  wire logic [wstm_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [wstm_pkg::PAT_WORD_W-1:0]    cfg_data
);
    import wstm_pkg::*;

    logic [PAT_WORD_W-1:0]   pat_low_reg;
    logic [PAT_WORD_W-1:0]   pat_high_reg;
    logic [PAT_LEN_W-1:0]    len_reg;
    logic [PAT_LEN_W-1:0]    len_act;

    char_t                   in_char_reg;
    logic                    in_last_reg;
    logic                    in_full_reg;
    logic                    in_full_next;
    logic                    out_valid_reg;
    logic                    out_valid_next;
    logic                    found_reg;
    logic [RESULT_OFS_W-1:0] offset_reg;

    logic                    accept;
    logic                    advance;
    logic                    out_free;
    scan_res_t               res;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pat_low_reg  <= '0;
            pat_high_reg <= '0;
            len_reg      <= PAT_LEN_W'(1);
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_PAT_LOW:  pat_low_reg  <= cfg_data;
                CFG_PAT_HIGH: pat_high_reg <= cfg_data;
                CFG_PAT_LEN:  len_reg      <= cfg_data[PAT_LEN_W-1:0];
                default:      ;
            endcase
        end
    end

    // zero length counts as one, anything above the maximum as the maximum
    always_comb
    begin
        if (len_reg == '0)
        begin
            len_act = PAT_LEN_W'(1);
        end
        else if (len_reg > PAT_LEN_W'(MAX_PATTERN))
        begin
            len_act = PAT_LEN_W'(MAX_PATTERN);
        end
        else
        begin
            len_act = len_reg;
        end
    end

    assign out_free = !out_valid_reg || !out_stall;
    // an item that produces no result never waits for the output side
    assign advance  = in_full_reg && (out_free || !res.emit);
    assign in_stall = in_full_reg && !advance;
    assign accept   = in_valid && !in_stall;

    assign in_full_next   = accept || (in_full_reg && !advance);
    assign out_valid_next = (advance && res.emit) || (out_valid_reg && out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_full_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_full_reg   <= in_full_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            in_char_reg <= text_char;
            in_last_reg <= last;
        end
        if (advance && res.emit)
        begin
            found_reg  <= res.found;
            offset_reg <= res.offset;
        end
    end

    wstm_scan #(
        .MAX_PATTERN (MAX_PATTERN),
        .OFFSET_BITS (OFFSET_BITS)
    ) u_scan (
        .clk      (clk),
        .rst_n    (rst_n),
        .step     (advance),
        .char_in  (in_char_reg),
        .last_in  (in_last_reg),
        .pat_low  (pat_low_reg),
        .pat_high (pat_high_reg),
        .pat_len  (len_act),
        .res      (res)
    );

    assign out_valid    = out_valid_reg;
    assign found        = found_reg;
    assign start_offset = offset_reg;

    a_no_stall_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        in_full_reg && !out_valid_reg |-> !in_stall)
        else $error("input stalled while result register is empty");

    a_not_found_zero_offset: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !found |-> start_offset == '0)
        else $error("not found result with nonzero offset");

    a_result_kept_when_stalled: assert property (@(posedge clk) disable iff (!rst_n)
        advance && res.emit |-> out_free)
        else $error("result register overwritten while stalled");

endmodule

`default_nettype wire
